FILE: src/ptfl_pkg.sv
package ptfl_pkg;

    localparam int NumFrames = 4;
    localparam int MaxProcs  = 4;
    localparam int MaxPages  = 16;

    // result status codes
    localparam logic [1:0] StHit    = 2'd0;
    localparam logic [1:0] StFill   = 2'd1;
    localparam logic [1:0] StEvict  = 2'd2;
    localparam logic [1:0] StReject = 2'd3;

    // register indexes
    localparam int RegMode     = 0;
    localparam int RegPageBits = 1;
    localparam int RegSize1    = 2;
    localparam int RegSize4    = 5;

    localparam logic [31:0] CntMax = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [3:0]  proc_id;
        logic [19:0] virtual_addr;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  page_number;
        logic [5:0]  frame_number;
        logic [21:0] physical_addr;
        logic [3:0]  evicted_proc;
        logic [5:0]  evicted_page;
        logic [31:0] fault_count;
        logic [31:0] access_count;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic update;
    } t_cmd;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        sat_inc = (v == CntMax) ? v : v + 32'd1;
    endfunction

endpackage

FILE: src/ptfl_ctrl.sv
module ptfl_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output ptfl_pkg::t_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_UPD  = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0] r_state, n_state;

    // state sequencing: capture, update, deliver
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_UPD;
            S_UPD:  n_state = S_OUT;
            S_OUT:  if (i_out_ready) n_state = i_in_valid ? S_UPD : S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready    = (r_state == S_IDLE) || (r_state == S_OUT && i_out_ready);
    assign o_out_valid   = (r_state == S_OUT);
    assign o_cmd.capture = i_in_valid && o_in_ready;
    assign o_cmd.update  = (r_state == S_UPD);

    a_upd_then_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_UPD |=> r_state == S_OUT) else $error("update not followed by output");
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid) else $error("output dropped");
    a_no_cap_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_UPD |-> !o_cmd.capture) else $error("capture while busy");

endmodule

FILE: src/ptfl_dp.sv
module ptfl_dp #(
    parameter int FRAME_SLOTS = ptfl_pkg::NumFrames,
    parameter int MAX_PROCS   = ptfl_pkg::MaxProcs,
    parameter int MAX_PAGES   = ptfl_pkg::MaxPages
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ptfl_pkg::t_cmd      i_cmd,
    input  ptfl_pkg::t_in_item  i_item,
    input  logic                i_mode,
    input  logic [4:0]          i_page_bits,
    input  logic [20:0]         i_size [MAX_PROCS],
    output ptfl_pkg::t_out_item o_item
);

    localparam int PtDepth = MAX_PROCS * MAX_PAGES;
    localparam int FW = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
    localparam int SW = (PtDepth > 1) ? $clog2(PtDepth) : 1;

    // page table: present bits as flops, frame index as a memory
    logic [PtDepth-1:0]  r_present;
    logic [FW-1:0]       r_pframe [PtDepth];
    logic [FRAME_SLOTS-1:0] r_fvalid;
    logic [3:0]          r_fowner [FRAME_SLOTS];
    logic [5:0]          r_fpage  [FRAME_SLOTS];
    logic [31:0]         r_fload  [FRAME_SLOTS];
    logic [31:0]         r_fuse   [FRAME_SLOTS];
    logic [31:0]         r_time, r_faults, r_accs;

    // captured item, decoded in the capture cycle
    logic        r_ok;
    logic [SW-1:0] r_slot;
    logic [5:0]  r_page;
    logic [19:0] r_off;
    logic [4:0]  r_sh;
    logic [3:0]  r_pid;
    logic [FW-1:0] r_pf_rd;
    ptfl_pkg::t_out_item r_out;

    logic [4:0]  sh;
    logic [19:0] page_full, off;
    logic        ok;
    logic [3:0]  pm1;
    logic [20:0] psize;
    logic [SW-1:0] slot_c;

    // decode: shift clamp, range checks
    always_comb begin
        sh = (i_page_bits < 5'd4) ? 5'd4 : (i_page_bits > 5'd16) ? 5'd16 : i_page_bits;
        page_full = i_item.virtual_addr >> sh;
        off = i_item.virtual_addr & ((20'd1 << sh) - 20'd1);
        pm1 = i_item.proc_id - 4'd1;
        psize = '0;
        for (int p = 0; p < MAX_PROCS; p++) begin
            if (pm1 == 4'(p)) psize = i_size[p];
        end
        ok = (i_item.proc_id >= 4'd1) && ({28'd0, i_item.proc_id} <= 32'(MAX_PROCS))
            && ({1'b0, i_item.virtual_addr} < psize)
            && ({12'd0, page_full} < 32'(MAX_PAGES));
    end

    assign slot_c = SW'(32'(pm1) * 32'(MAX_PAGES) + 32'(page_full));

    // victim search and empty-frame search
    logic [FW-1:0] empty_idx, vict_idx, frame;
    logic          empty_found, hit;
    logic [31:0]   best_t, t_i;
    logic [1:0]    status;
    logic [3:0]    ev_proc;
    logic [5:0]    ev_page;
    logic [31:0]   old_slot_w;
    logic [PtDepth-1:0] n_present;

    always_comb begin
        empty_found = 1'b0;
        empty_idx = '0;
        for (int i = FRAME_SLOTS - 1; i >= 0; i--) begin
            if (!r_fvalid[i]) begin
                empty_found = 1'b1;
                empty_idx = FW'(i);
            end
        end
        vict_idx = '0;
        best_t = i_mode ? r_fuse[0] : r_fload[0];
        for (int i = 1; i < FRAME_SLOTS; i++) begin
            t_i = i_mode ? r_fuse[i] : r_fload[i];
            if (t_i < best_t) begin
                best_t = t_i;
                vict_idx = FW'(i);
            end
        end
        t_i = '0;
        hit = r_present[r_slot];
        ev_proc = '0;
        ev_page = '0;
        if (hit) begin
            frame = r_pf_rd;
            status = ptfl_pkg::StHit;
        end else if (empty_found) begin
            frame = empty_idx;
            status = ptfl_pkg::StFill;
        end else begin
            frame = vict_idx;
            status = ptfl_pkg::StEvict;
            ev_proc = r_fowner[vict_idx];
            ev_page = r_fpage[vict_idx];
        end
        old_slot_w = (32'(ev_proc) - 32'd1) * 32'(MAX_PAGES) + 32'(ev_page);
    end

    // present bits after a fault: drop the evicted page, mark the new one
    always_comb begin
        n_present = r_present;
        if (status == ptfl_pkg::StEvict && old_slot_w < 32'(PtDepth) && ev_proc != 4'd0)
            n_present[old_slot_w[SW-1:0]] = 1'b0;
        n_present[r_slot] = 1'b1;
    end

    logic [31:0] n_faults, n_accs;
    assign n_accs   = ptfl_pkg::sat_inc(r_accs);
    assign n_faults = hit ? r_faults : ptfl_pkg::sat_inc(r_faults);

    // control state of the tables and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present <= '0;
            r_fvalid  <= '0;
            r_time    <= '0;
            r_faults  <= '0;
            r_accs    <= '0;
        end else if (i_cmd.update && r_ok) begin
            r_accs <= n_accs;
            r_faults <= n_faults;
            r_time <= ptfl_pkg::sat_inc(r_time);
            if (!hit) begin
                r_present <= n_present;
                r_fvalid[frame] <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_ok    <= ok;
            r_slot  <= slot_c;
            r_page  <= page_full[5:0];
            r_off   <= off;
            r_sh    <= sh;
            r_pid   <= i_item.proc_id;
            r_pf_rd <= r_pframe[slot_c];
        end
        if (i_cmd.update) begin
            if (r_ok) begin
                if (!hit) begin
                    r_pframe[r_slot] <= frame;
                    r_fowner[frame]  <= r_pid;
                    r_fpage[frame]   <= r_page;
                    r_fload[frame]   <= r_time;
                end
                r_fuse[frame] <= r_time;
                r_out.status        <= status;
                r_out.page_number   <= r_page;
                r_out.frame_number  <= 6'(frame);
                r_out.physical_addr <= (22'(frame) << r_sh) | 22'(r_off);
                r_out.evicted_proc  <= ev_proc;
                r_out.evicted_page  <= ev_page;
                r_out.fault_count   <= n_faults;
                r_out.access_count  <= n_accs;
            end else begin
                r_out.status        <= ptfl_pkg::StReject;
                r_out.page_number   <= '0;
                r_out.frame_number  <= '0;
                r_out.physical_addr <= '0;
                r_out.evicted_proc  <= '0;
                r_out.evicted_page  <= '0;
                r_out.fault_count   <= r_faults;
                r_out.access_count  <= r_accs;
            end
        end
    end

    assign o_item = r_out;

    a_time_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> r_time >= $past(r_time)) else $error("time went back");
    a_fault_le_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_faults <= r_accs) else $error("faults exceed accesses");
    a_reject_still: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.update && !r_ok |=> $stable(r_time)) else $error("reject moved time");

endmodule

FILE: src/paging_translator_fifo_lru_unit.sv
// demand paging translator with fifo or lru frame replacement
// input channel (i_in_valid/o_in_ready) carries a process id and virtual address;
// output channel (o_out_valid/i_out_ready) returns one result item per input item:
// status, page, frame, physical address, eviction info and saturating counts.
// apb port programs replace mode, page bits and four process sizes at 4*index.
// an item is accepted, updated in the next cycle, and shown on the
// output the cycle after. the page table read is registered at acceptance;
// the timestamp compare over all frames sits in the update cycle.
// a new item is taken in the same cycle the pending result is taken.
// reset clears the page table valid bits, frame valid bits, time and counters;
// registers return to fifo mode, 12 page bits and no processes.
// when the receiver stalls, the result holds and no new item is accepted.
module paging_translator_fifo_lru_unit #(
    parameter int FRAME_SLOTS = ptfl_pkg::NumFrames,
    parameter int MAX_PROCS   = ptfl_pkg::MaxProcs,
    parameter int MAX_PAGES   = ptfl_pkg::MaxPages
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  ptfl_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ptfl_pkg::t_out_item o_out_item,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic        r_mode;
    logic [4:0]  r_page_bits;
    logic [20:0] r_size [MAX_PROCS];
    logic [2:0]  ridx;
    ptfl_pkg::t_cmd cmd;

    assign pready = 1'b1;
    assign ridx = paddr[4:2];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_page_bits <= 5'd12;
            for (int p = 0; p < MAX_PROCS; p++) r_size[p] <= '0;
        end else if (psel && penable && pwrite) begin
            if (ridx == 3'(ptfl_pkg::RegMode)) r_mode <= pwdata[0];
            if (ridx == 3'(ptfl_pkg::RegPageBits)) r_page_bits <= pwdata[4:0];
            for (int p = 0; p < MAX_PROCS; p++) begin
                if (ridx == 3'(ptfl_pkg::RegSize1 + p) && p <= ptfl_pkg::RegSize4 - 2)
                    r_size[p] <= pwdata[20:0];
            end
        end
    end

    // register read
    always_comb begin
        prdata = '0;
        if (ridx == 3'(ptfl_pkg::RegMode)) prdata = {31'd0, r_mode};
        if (ridx == 3'(ptfl_pkg::RegPageBits)) prdata = {27'd0, r_page_bits};
        for (int p = 0; p < MAX_PROCS; p++) begin
            if (ridx == 3'(ptfl_pkg::RegSize1 + p)) prdata = {11'd0, r_size[p]};
        end
    end

    ptfl_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_ready, .o_out_valid, .i_out_ready,
        .o_cmd(cmd)
    );

    ptfl_dp #(.FRAME_SLOTS(FRAME_SLOTS), .MAX_PROCS(MAX_PROCS), .MAX_PAGES(MAX_PAGES)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .i_item(i_in_item), .i_mode(r_mode),
        .i_page_bits(r_page_bits), .i_size(r_size), .o_item(o_out_item)
    );

endmodule
